>>> design/ote_pkg.sv
// Shared types and codes for the order table engine.
package ote_pkg;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_SEARCH = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_RESP
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic start;
    logic scan;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_done;
    logic scan_done;
    logic match_now;
  } stat_t;

endpackage

>>> design/ote_ctrl.sv
// Sequencer for clearing, scanning, committing and responding.
module ote_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_ready_i,
  input  ote_pkg::stat_t stat_i,
  output ote_pkg::cmd_t  cmd_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  import ote_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR:  if (stat_i.clear_done) state_d = S_IDLE;
      S_IDLE:   if (in_valid_i) state_d = S_SCAN;
      S_SCAN:   if (stat_i.scan_done || stat_i.match_now) state_d = S_DECIDE;
      S_DECIDE: state_d = S_RESP;
      S_RESP:   if (out_ready_i) state_d = S_IDLE;
      default:  state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_CLEAR:  cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      S_SCAN:   cmd_o.scan = 1'b1;
      S_DECIDE: cmd_o.commit = 1'b1;
      S_RESP:   out_valid_o = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

>>> design/ote_datapath.sv
// Slot memory, scan tracking, update arithmetic and result registers.
module ote_datapath #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 64,
  parameter int QTY_BITS   = 32,
  parameter int PRICE_BITS = 32,
  parameter int CW         = $clog2(CAPACITY + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ote_pkg::cmd_t         cmd_i,
  output ote_pkg::stat_t        stat_o,
  input  logic [1:0]            mode_i,
  input  logic [KEY_BITS-1:0]   order_id_i,
  input  logic                  side_i,
  input  logic [QTY_BITS-1:0]   quantity_i,
  input  logic [PRICE_BITS-1:0] price_i,
  output logic [1:0]            status_o,
  output logic                  found_side_o,
  output logic [QTY_BITS-1:0]   found_quantity_o,
  output logic [PRICE_BITS-1:0] found_price_o,
  output logic [CW-1:0]         orders_held_o,
  output logic                  table_empty_o
);
  import ote_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int EW = 1 + KEY_BITS + 1 + QTY_BITS + PRICE_BITS;
  localparam logic [AW-1:0] LAST = AW'(CAPACITY - 1);

  // word layout: valid, key, side, quantity, price
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_idx_q;
  logic [AW-1:0] addr_q;
  logic          issued_q;

  logic                  rd_valid;
  logic [KEY_BITS-1:0]   rd_key;
  logic                  rd_side;
  logic [QTY_BITS-1:0]   rd_qty;
  logic [PRICE_BITS-1:0] rd_price;
  assign {rd_valid, rd_key, rd_side, rd_qty, rd_price} = rd_q;

  // captured request
  mode_e                 mode_q;
  logic [KEY_BITS-1:0]   key_q;
  logic                  side_q;
  logic [QTY_BITS-1:0]   qty_q;
  logic [PRICE_BITS-1:0] price_q;

  // scan results
  logic                  hit_q, free_ok_q;
  logic [AW-1:0]         hit_idx_q, free_idx_q;
  logic                  hit_side_q;
  logic [QTY_BITS-1:0]   hit_qty_q;
  logic [PRICE_BITS-1:0] hit_price_q;

  logic [CW-1:0] occ_q, occ_d;

  logic match_now;
  assign match_now = rd_vld_q && rd_valid && (rd_key == key_q);

  assign stat_o.match_now  = match_now;
  assign stat_o.scan_done  = rd_vld_q && (rd_idx_q == LAST);
  assign stat_o.clear_done = cmd_i.clear && (addr_q == LAST);

  // commit decision
  logic                  we;
  logic [AW-1:0]         wr_addr;
  logic [EW-1:0]         wr_data;
  logic [QTY_BITS-1:0]   left;
  logic [1:0]            res_status;
  logic                  res_side;
  logic [QTY_BITS-1:0]   res_qty;
  logic [PRICE_BITS-1:0] res_price;

  always_comb begin
    left = (qty_q == '0 || qty_q >= hit_qty_q) ? '0 : hit_qty_q - qty_q;
    we         = 1'b0;
    wr_addr    = hit_idx_q;
    wr_data    = {1'b1, key_q, side_q, qty_q, price_q};
    occ_d      = occ_q;
    res_status = ST_OK;
    res_side   = 1'b0;
    res_qty    = '0;
    res_price  = '0;
    if (cmd_i.clear) begin
      we      = 1'b1;
      wr_addr = addr_q;
      wr_data = '0;
    end else if (cmd_i.commit) begin
      case (mode_q)
        MODE_ADD: begin
          if (hit_q || (occ_q < CW'(CAPACITY) && free_ok_q)) begin
            we = 1'b1;
            if (!hit_q) begin
              wr_addr = free_idx_q;
              occ_d   = occ_q + 1'b1;
            end
            res_side  = side_q;
            res_qty   = qty_q;
            res_price = price_q;
          end else begin
            res_status = ST_FULL;
          end
        end
        MODE_SEARCH, MODE_MODIFY: begin
          if (!hit_q) begin
            res_status = ST_NOT_FOUND;
          end else begin
            res_side  = hit_side_q;
            res_price = hit_price_q;
            if (mode_q == MODE_MODIFY) begin
              we      = 1'b1;
              res_qty = left;
              if (left == '0) begin
                wr_data = '0;
                if (occ_q != '0) occ_d = occ_q - 1'b1;
              end else begin
                wr_data = {1'b1, key_q, hit_side_q, left, hit_price_q};
              end
            end else begin
              res_qty = hit_qty_q;
            end
          end
        end
        default: res_status = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= '0;
      issued_q  <= 1'b0;
      rd_vld_q  <= 1'b0;
      hit_q     <= 1'b0;
      free_ok_q <= 1'b0;
      occ_q     <= '0;
    end else begin
      occ_q    <= occ_d;
      rd_vld_q <= cmd_i.scan && !issued_q && !match_now;
      if (cmd_i.clear) begin
        addr_q <= (addr_q == LAST) ? '0 : addr_q + 1'b1;
      end else if (cmd_i.start) begin
        addr_q    <= '0;
        issued_q  <= 1'b0;
        hit_q     <= 1'b0;
        free_ok_q <= 1'b0;
      end else if (cmd_i.scan) begin
        if (addr_q == LAST) issued_q <= 1'b1;
        else addr_q <= addr_q + 1'b1;
        if (match_now) hit_q <= 1'b1;
        if (rd_vld_q && !rd_valid && !free_ok_q) free_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= addr_q;
    if (cmd_i.start) begin
      mode_q  <= mode_e'(mode_i);
      key_q   <= order_id_i;
      side_q  <= side_i;
      qty_q   <= quantity_i;
      price_q <= price_i;
    end
    if (cmd_i.scan && match_now) begin
      hit_idx_q   <= rd_idx_q;
      hit_side_q  <= rd_side;
      hit_qty_q   <= rd_qty;
      hit_price_q <= rd_price;
    end
    if (cmd_i.scan && rd_vld_q && !rd_valid && !free_ok_q) free_idx_q <= rd_idx_q;
    if (cmd_i.commit) begin
      status_o         <= res_status;
      found_side_o     <= res_side;
      found_quantity_o <= res_qty;
      found_price_o    <= res_price;
    end
  end

  assign orders_held_o = occ_q;
  assign table_empty_o = (occ_q == '0);

endmodule

>>> design/order_table_engine.sv
// Top level of the order table engine: controller, datapath and checks.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------
//  in      | request   | in_valid_i/in_ready_o | mode, order_id, side, qty, price
//  out     | result    | out_valid_o/out_ready_i | status, found_*, orders_held, empty
//
// After reset a clearing pass marks every slot free; in_ready_o stays low
// until it ends. A request walks the single read port of the slot memory
// one slot a cycle until the id is found or the last slot is read; then a
// commit step writes the slot when the request adds, changes or frees it.
// One request is in flight at a time; a stalled result holds the block.
module order_table_engine #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 64,
  parameter int QTY_BITS   = 32,
  parameter int PRICE_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         mode_i,
  input  logic [KEY_BITS-1:0]                order_id_i,
  input  logic                               side_i,
  input  logic [QTY_BITS-1:0]                quantity_i,
  input  logic [PRICE_BITS-1:0]              price_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic                               found_side_o,
  output logic [QTY_BITS-1:0]                found_quantity_o,
  output logic [PRICE_BITS-1:0]              found_price_o,
  output logic [$clog2(CAPACITY + 1)-1:0]    orders_held_o,
  output logic                               table_empty_o
);
  import ote_pkg::*;

  // width of the order count, 0 to CAPACITY inclusive
  localparam int CW = $clog2(CAPACITY + 1);

  cmd_t  cmd;
  stat_t stat;

  // sequencer: clear, accept, scan, commit, respond
  ote_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o)
  );

  // slot memory and result registers
  ote_datapath #(
    .CAPACITY   (CAPACITY),
    .KEY_BITS   (KEY_BITS),
    .QTY_BITS   (QTY_BITS),
    .PRICE_BITS (PRICE_BITS),
    .CW         (CW)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .mode_i           (mode_i),
    .order_id_i       (order_id_i),
    .side_i           (side_i),
    .quantity_i       (quantity_i),
    .price_i          (price_i),
    .status_o         (status_o),
    .found_side_o     (found_side_o),
    .found_quantity_o (found_quantity_o),
    .found_price_o    (found_price_o),
    .orders_held_o    (orders_held_o),
    .table_empty_o    (table_empty_o)
  );

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("request accepted with result pending");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    orders_held_o <= CW'(CAPACITY)) else $error("occupancy above capacity");

  a_full_means_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_FULL) |-> orders_held_o == CW'(CAPACITY))
    else $error("table full reported below capacity");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (table_empty_o == (orders_held_o == '0)))
    else $error("empty flag disagrees with count");
`endif

endmodule

>>> test/tb_order_table_engine.sv
// Testbench for the order table engine: random and directed requests checked against a predictor.
`timescale 1ns / 100ps

module tb_order_table_engine;
  import ote_pkg::*;

  localparam int unsigned TABLE_SLOTS = 1024;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;
  localparam int unsigned RAND_ITEMS  = 270;  // per idling phase
  localparam int unsigned POOL_IDS    = 48;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] order_id;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] price;
  } request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        side;
    logic [31:0] quantity;
    logic [31:0] price;
    logic [10:0] held;
    logic        empty;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = MODE_NONE;
  logic [63:0] order_id_i = '0;
  logic side_i = 1'b0;
  logic [31:0] quantity_i = '0;
  logic [31:0] price_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [1:0] status_o;
  logic found_side_o;
  logic [31:0] found_quantity_o;
  logic [31:0] found_price_o;
  logic [10:0] orders_held_o;
  logic table_empty_o;

  order_table_engine u_dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .mode_i, .order_id_i, .side_i, .quantity_i, .price_i,
    .out_valid_o, .out_ready_i,
    .status_o, .found_side_o, .found_quantity_o, .found_price_o,
    .orders_held_o, .table_empty_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Book mirror: the open orders keyed by id
  logic        book_side  [logic [63:0]];
  logic [31:0] book_qty   [logic [63:0]];
  logic [31:0] book_price [logic [63:0]];

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  logic [63:0] id_pool[$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_count = 0;
  bit          in_taken = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned answers_seen = 0;
  int unsigned full_seen = 0;
  int unsigned removals_seen = 0;

  // Apply one request to the mirror and return the answer the engine should give
  function automatic answer_t book_apply(request_t r);
    answer_t a;
    logic [31:0] left;
    bit known;
    a = '0;
    a.status = ST_OK;
    known = (book_qty.exists(r.order_id) != 0);
    case (r.mode)
      MODE_ADD: begin
        if (!known && book_qty.num() >= TABLE_SLOTS) begin
          a.status = ST_FULL;
        end else begin
          book_side[r.order_id]  = r.side;
          book_qty[r.order_id]   = r.quantity;
          book_price[r.order_id] = r.price;
          a.side = r.side;
          a.quantity = r.quantity;
          a.price = r.price;
        end
      end
      MODE_SEARCH, MODE_MODIFY: begin
        if (!known) begin
          a.status = ST_NOT_FOUND;
        end else begin
          a.side  = book_side[r.order_id];
          a.price = book_price[r.order_id];
          if (r.mode == MODE_MODIFY) begin
            left = (r.quantity == 0 || r.quantity >= book_qty[r.order_id]) ?
                   32'd0 : book_qty[r.order_id] - r.quantity;
            if (left == 0) begin
              book_side.delete(r.order_id);
              book_qty.delete(r.order_id);
              book_price.delete(r.order_id);
            end else begin
              book_qty[r.order_id] = left;
            end
            a.quantity = left;
          end else begin
            a.quantity = book_qty[r.order_id];
          end
        end
      end
      default: ;
    endcase
    a.held  = 11'(book_qty.num());
    a.empty = (book_qty.num() == 0);
    return a;
  endfunction

  function automatic request_t make_req(logic [1:0] m, logic [63:0] id, logic s,
                                        logic [31:0] q, logic [31:0] p);
    request_t r;
    r.mode = m;
    r.order_id = id;
    r.side = s;
    r.quantity = q;
    r.price = p;
    return r;
  endfunction

  function automatic logic [63:0] rand_id();
    return {$urandom, $urandom};
  endfunction

  // Quantities: mostly small so reductions leave something, sometimes huge or zero
  function automatic logic [31:0] rand_qty();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 32'd0;
    if (pick < 70) return $urandom_range(1, 40);
    return $urandom;
  endfunction

  function automatic request_t rand_req();
    int unsigned pick;
    logic [63:0] id;
    pick = $urandom_range(99);
    id = (pick < 92) ? id_pool[$urandom_range(id_pool.size() - 1)] : rand_id();
    pick = $urandom_range(99);
    if (pick < 38)
      return make_req(MODE_ADD, id, 1'($urandom_range(1)), rand_qty(), $urandom);
    if (pick < 62)
      return make_req(MODE_SEARCH, id, 1'($urandom_range(1)), $urandom, $urandom);
    if (pick < 95)
      return make_req(MODE_MODIFY, id, 1'($urandom_range(1)), rand_qty(), $urandom);
    return make_req(MODE_NONE, id, 1'($urandom_range(1)), $urandom, $urandom);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid_i || expected_answers.size() != 0)
      @(posedge clk_i);
  endtask

  // Sender: new request on the falling edge, held until accepted
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        mode_i     <= r.mode;
        order_id_i <= r.order_id;
        side_i     <= r.side;
        quantity_i <= r.quantity;
        price_i    <= r.price;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off that backs up the sender
  always @(negedge clk_i) begin
    if (hold_request && !hold_started) begin
      hold_started <= 1'b1;
      hold_count   <= 400;
      out_ready_i  <= 1'b0;
    end else if (hold_count != 0) begin
      hold_count  <= hold_count - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Request side: predict on acceptance
  always @(posedge clk_i) begin
    in_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o)
      expected_answers.push_back(book_apply(make_req(mode_i, order_id_i, side_i,
                                                     quantity_i, price_i)));
  end

  // Result side: compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      answer_t want;
      answer_t got;
      got = {status_o, found_side_o, found_quantity_o, found_price_o,
             orders_held_o, table_empty_o};
      answers_seen <= answers_seen + 1;
      if (expected_answers.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected result, got %p", $realtime, got);
      end else begin
        want = expected_answers.pop_front();
        if (want.status == ST_FULL) full_seen <= full_seen + 1;
        if (want.status != got.status)
          $display("%0t: status exp %0d got %0d", $realtime, want.status, got.status);
        if (want.side != got.side)
          $display("%0t: side exp %0d got %0d", $realtime, want.side, got.side);
        if (want.quantity != got.quantity)
          $display("%0t: quantity exp %0d got %0d", $realtime, want.quantity, got.quantity);
        if (want.price != got.price)
          $display("%0t: price exp %0d got %0d", $realtime, want.price, got.price);
        if (want.held != got.held)
          $display("%0t: held exp %0d got %0d", $realtime, want.held, got.held);
        if (want.empty != got.empty)
          $display("%0t: empty exp %0d got %0d", $realtime, want.empty, got.empty);
        if (want != got) errors <= errors + 1;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [63:0] ones;
    logic [63:0] fresh;
    logic [63:0] held_id;
    bit          used_ids [logic [63:0]];
    int unsigned to_fill;
    ones = '1;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // clearing pass after reset
    while (!in_ready_o) @(posedge clk_i);

    // Directed: extremes, zero quantity, absent ids, saturation, unused mode
    recv_stall_pct = 20;
    pending_reqs.push_back(make_req(MODE_SEARCH, 64'd0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(MODE_MODIFY, 64'd0, 1'b0, 32'd5, '0));
    pending_reqs.push_back(make_req(MODE_ADD, 64'd0, 1'b0, 32'd0, 32'd0));
    pending_reqs.push_back(make_req(MODE_ADD, ones, 1'b1, '1, '1));
    pending_reqs.push_back(make_req(MODE_SEARCH, ones, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(MODE_SEARCH, 64'd0, 1'b1, '1, '1));
    pending_reqs.push_back(make_req(MODE_MODIFY, ones, 1'b0, 32'd1, '1));
    pending_reqs.push_back(make_req(MODE_SEARCH, ones, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(MODE_ADD, ones, 1'b0, 32'd10, 32'd77));
    pending_reqs.push_back(make_req(MODE_MODIFY, ones, 1'b1, 32'd11, '0));
    pending_reqs.push_back(make_req(MODE_SEARCH, ones, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(MODE_NONE, 64'h5555_AAAA_5555_AAAA, 1'b1, '1, '1));
    pending_reqs.push_back(make_req(MODE_MODIFY, 64'd0, 1'b1, 32'd3, '1));
    pending_reqs.push_back(make_req(MODE_ADD, 64'hAAAA_5555_AAAA_5555, 1'b1, 32'd9, 32'd4));
    pending_reqs.push_back(make_req(MODE_ADD, 64'hAAAA_5555_AAAA_5555, 1'b0, 32'd2, 32'd8));
    pending_reqs.push_back(make_req(MODE_MODIFY, 64'hAAAA_5555_AAAA_5555, 1'b0, 32'd0, '0));
    pending_reqs.push_back(make_req(MODE_NONE, 64'd0, 1'b0, '0, '0));
    wait_drained();

    // Random traffic over a small pool of live ids
    for (int i = 0; i < POOL_IDS; i++) id_pool.push_back(rand_id());
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 52 : 0;
      recv_stall_pct = (ph == 0) ? 52 : (ph == 1) ? 14 : 0;
      for (int i = 0; i < RAND_ITEMS; i++) pending_reqs.push_back(rand_req());
      if (ph == 2) hold_request = 1'b1;
      wait_drained();
    end

    // Fill the table to capacity, then exercise the full cases
    recv_stall_pct = 10;
    send_idle_pct  = 10;
    foreach (book_qty[k]) used_ids[k] = 1'b1;
    to_fill = TABLE_SLOTS - book_qty.num();
    for (int i = 0; i < to_fill; i++) begin
      do fresh = rand_id(); while (used_ids.exists(fresh));
      used_ids[fresh] = 1'b1;
      pending_reqs.push_back(make_req(MODE_ADD, fresh, 1'($urandom_range(1)),
                                      $urandom_range(1, 1000), $urandom));
    end
    held_id = fresh;
    pending_reqs.push_back(make_req(MODE_ADD, ~held_id, 1'b1, 32'd5, 32'd6));
    pending_reqs.push_back(make_req(MODE_ADD, held_id, 1'b1, '1, '1));
    pending_reqs.push_back(make_req(MODE_SEARCH, held_id, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(MODE_MODIFY, held_id, 1'b0, 32'd0, '0));
    pending_reqs.push_back(make_req(MODE_ADD, ~held_id, 1'b0, 32'd7, 32'd8));
    pending_reqs.push_back(make_req(MODE_ADD, held_id, 1'b1, 32'd1, 32'd1));
    pending_reqs.push_back(make_req(MODE_NONE, held_id, 1'b1, '1, '1));
    wait_drained();
    repeat (TABLE_SLOTS + 20) @(posedge clk_i);

    $display("covered %0d results: directed edge cases, three idling mixes with a long",
             answers_seen);
    $display("output hold-off, and a full table (%0d full rejects)", full_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/ote_pkg.sv
design/ote_ctrl.sv
design/ote_datapath.sv
design/order_table_engine.sv
test/tb_order_table_engine.sv
